// ----- rtl/isf_pkg.sv -----
// Shared types and constants for the Ising spin flip trial engine.
// No dependencies. Used by the channel interfaces and the top level.
package isf_pkg;

  // Lattice side length used when the top level is not given one.
  localparam int unsigned SIDE_DEFAULT = 64;

  // Fixed field widths of the channels.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned ENERGY_W = 15;
  localparam int unsigned DRAW_W   = 32;
  localparam int unsigned DELTA_W  = 5;
  localparam int unsigned THRESH_W = 33;
  localparam int unsigned CFG_IDX_W = 3;

  // Number of coordinate codes that the row and column fields can carry.
  localparam int unsigned COORD_RANGE = 2 ** COORD_W;

  // One threshold register per possible energy change.
  localparam int unsigned NUM_THRESH = 5;

  // Saturation bounds of the running energy.
  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = 15'sh3FFF;
  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = 15'sh4000;

  // Threshold values after reset, in order of rising energy change.
  localparam logic [THRESH_W-1:0] THRESH_RESET [NUM_THRESH] = '{
    33'd4294967296, 33'd4294967296, 33'd4294967296, 33'd78665071, 33'd1440799
  };

  // Item kinds carried in the action field.
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_SPIN   = 2'd0,
    ACT_LOAD_ENERGY = 2'd1,
    ACT_FLIP_TRIAL  = 2'd2
  } isf_action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH_MINUS8 = 3'd0,
    CFG_THRESH_MINUS4 = 3'd1,
    CFG_THRESH_ZERO   = 3'd2,
    CFG_THRESH_PLUS4  = 3'd3,
    CFG_THRESH_PLUS8  = 3'd4
  } isf_cfg_reg_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_SIDES,
    ST_READ_CENTER,
    ST_EVAL
  } isf_state_e;

endpackage

// ----- rtl/isf_if.sv -----
// Valid/ready channel interfaces of the spin flip trial engine.
// Depends on isf_pkg for the field widths.

// Trial channel: one word per load or flip trial.
interface isf_trial_if import isf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [COORD_W-1:0]         row;
  logic [COORD_W-1:0]         col;
  logic                       spin_value;
  logic signed [ENERGY_W-1:0] energy_value;
  logic [DRAW_W-1:0]          random_draw;

  modport source (output valid, action, row, col, spin_value, energy_value, random_draw,
                  input ready);
  modport sink   (input valid, action, row, col, spin_value, energy_value, random_draw,
                  output ready);
endinterface

// Result channel: one word per accepted trial word.
interface isf_result_if import isf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic signed [DELTA_W-1:0]  delta_energy;
  logic signed [ENERGY_W-1:0] energy;
  logic                       spin_after;

  modport source (output valid, accepted, delta_energy, energy, spin_after,
                  input ready);
  modport sink   (input valid, accepted, delta_energy, energy, spin_after,
                  output ready);
endinterface

// Configuration write channel: register index and write data.
interface isf_cfg_if import isf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [THRESH_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ising_spin_flip_trial.sv -----
// Single-site Metropolis trial engine for a periodic 2D Ising lattice.
// A flip trial reads the vertical neighbors as it is accepted, then the horizontal
// neighbors in ST_READ_SIDES and the center in ST_READ_CENTER; ST_EVAL evaluates, writes
// back and registers the result word. A load goes from ST_IDLE straight to ST_EVAL.
// One word in flight: a new word is taken only in ST_IDLE, and ST_EVAL waits while the
// result register stays full. Reset: thresholds and energy return to
// their defaults; the lattice memory is not cleared and holds garbage until loaded.
module ising_spin_flip_trial import isf_pkg::*; #(
  parameter int unsigned SIDE = SIDE_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  isf_trial_if.sink    trial_i,
  isf_cfg_if.sink      cfg_i,
  isf_result_if.source result_o
);

  localparam int unsigned CW        = $clog2(SIDE);
  localparam int unsigned LAT_DEPTH = SIDE * SIDE;
  localparam int unsigned AW        = $clog2(LAT_DEPTH);

  // Flat address of a lattice site.
  function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
    logic [AW-1:0] base;
    base = AW'(r) * AW'(SIDE);
    return base + AW'(c);
  endfunction

  // Sequencer and captured word.
  isf_state_e                 state_q, state_d;
  logic [ACTION_W-1:0]        act_q;
  logic [CW-1:0]              r_q, c_q;
  logic                       sv_q;
  logic signed [ENERGY_W-1:0] energy_in_q;
  logic [DRAW_W-1:0]          draw_q;

  // Lattice memory and its registered read data.
  logic                       lattice_mem [LAT_DEPTH];
  logic                       rd_a_q, rd_b_q;
  logic [1:0]                 pair_q;
  logic [2:0]                 ones_q;

  // Architectural state.
  logic signed [ENERGY_W-1:0] energy_q, energy_d;
  logic [THRESH_W-1:0]        thresh_q [NUM_THRESH];

  // Result register.
  logic                       out_valid_q;
  logic                       out_acc_q;
  logic signed [DELTA_W-1:0]  out_de_q;
  logic signed [ENERGY_W-1:0] out_energy_q;
  logic                       out_spin_q;

  // Coordinate reduction table, worked out at elaboration.
  logic [CW-1:0] coord_mod [COORD_RANGE];
  for (genvar g = 0; g < COORD_RANGE; g++) begin : g_coord_mod
    assign coord_mod[g] = CW'(g % SIDE);
  end

  // Site in use: straight from the channel while idle, captured afterwards.
  logic [CW-1:0] base_r, base_c, r_up, r_dn, c_lf, c_rt;
  logic [AW-1:0] addr_center;
  assign base_r = (state_q == ST_IDLE) ? coord_mod[trial_i.row] : r_q;
  assign base_c = (state_q == ST_IDLE) ? coord_mod[trial_i.col] : c_q;
  assign r_dn   = (base_r == '0) ? CW'(SIDE - 1) : base_r - CW'(1);
  assign r_up   = (base_r == CW'(SIDE - 1)) ? '0 : base_r + CW'(1);
  assign c_lf   = (base_c == '0) ? CW'(SIDE - 1) : base_c - CW'(1);
  assign c_rt   = (base_c == CW'(SIDE - 1)) ? '0 : base_c + CW'(1);
  assign addr_center = site_addr(base_r, base_c);

  // Evaluation of the trial from the neighbor count and the center spin.
  logic                       is_trial, is_load_spin, center, acc, eval_go;
  logic [2:0]                 thr_idx;
  logic signed [DELTA_W:0]    de_wide;
  logic signed [DELTA_W-1:0]  de;
  logic signed [ENERGY_W:0]   e_sum;
  logic signed [ENERGY_W-1:0] e_sat;

  assign is_trial     = (act_q == ACT_FLIP_TRIAL);
  assign is_load_spin = (act_q == ACT_LOAD_SPIN);
  assign center       = rd_a_q;
  assign thr_idx      = center ? ones_q : 3'd4 - ones_q;
  assign de_wide      = $signed({1'b0, thr_idx, 2'b00}) - 6'sd8;
  assign de           = de_wide[DELTA_W-1:0];
  assign acc          = is_trial && ({1'b0, draw_q} < thresh_q[thr_idx]);
  assign e_sum        = {energy_q[ENERGY_W-1], energy_q}
                      + {{(ENERGY_W + 1 - DELTA_W){de[DELTA_W-1]}}, de};
  assign e_sat        = (e_sum[ENERGY_W] != e_sum[ENERGY_W-1])
                      ? (e_sum[ENERGY_W] ? ENERGY_MIN : ENERGY_MAX)
                      : e_sum[ENERGY_W-1:0];

  // Next energy value once the word completes.
  always_comb begin
    energy_d = energy_q;
    if (act_q == ACT_LOAD_ENERGY) begin
      energy_d = energy_in_q;
    end else if (acc) begin
      energy_d = e_sat;
    end
  end

  // Next state, read port control and write-back.
  logic          rd_a_en, rd_b_en, wr_en, wr_data;
  logic [AW-1:0] addr_a, addr_b;
  logic          trial_accept;

  assign trial_accept = trial_i.valid && trial_i.ready;

  always_comb begin
    state_d       = state_q;
    trial_i.ready = 1'b0;
    rd_a_en       = 1'b0;
    rd_b_en       = 1'b0;
    addr_a        = addr_center;
    addr_b        = addr_center;
    eval_go       = 1'b0;
    wr_en         = 1'b0;
    wr_data       = is_load_spin ? sv_q : ~center;
    case (state_q)
      ST_IDLE: begin
        trial_i.ready = 1'b1;
        if (trial_i.valid) begin
          if (trial_i.action == ACT_FLIP_TRIAL) begin
            // Vertical neighbors first.
            addr_a  = site_addr(r_dn, base_c);
            addr_b  = site_addr(r_up, base_c);
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
            state_d = ST_READ_SIDES;
          end else begin
            // Loads only need the site itself, and a spin load not even that.
            rd_a_en = (trial_i.action != ACT_LOAD_SPIN);
            state_d = ST_EVAL;
          end
        end
      end
      ST_READ_SIDES: begin
        addr_a  = site_addr(base_r, c_lf);
        addr_b  = site_addr(base_r, c_rt);
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
        state_d = ST_READ_CENTER;
      end
      ST_READ_CENTER: begin
        rd_a_en = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        // Complete only when the result register can take the word.
        if (!out_valid_q || result_o.ready) begin
          eval_go = 1'b1;
          wr_en   = is_load_spin || acc;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Lattice memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lattice_mem[addr_center] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_q <= lattice_mem[addr_a];
    end
    if (rd_b_en) begin
      rd_b_q <= lattice_mem[addr_b];
    end
  end

  // Neighbor count accumulated over the read cycles.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ_SIDES) begin
      pair_q <= {1'b0, rd_a_q} + {1'b0, rd_b_q};
    end
    if (state_q == ST_READ_CENTER) begin
      ones_q <= {1'b0, pair_q} + {2'b00, rd_a_q} + {2'b00, rd_b_q};
    end
  end

  // Captured word fields.
  always_ff @(posedge clk_i) begin
    if (trial_accept) begin
      act_q       <= trial_i.action;
      r_q         <= base_r;
      c_q         <= base_c;
      sv_q        <= trial_i.spin_value;
      energy_in_q <= trial_i.energy_value;
      draw_q      <= trial_i.random_draw;
    end
  end

  // Energy register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
    end else if (eval_go) begin
      energy_q <= energy_d;
    end
  end

  // Threshold registers, written through the configuration channel.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_THRESH_MINUS8: thresh_q[0] <= cfg_i.data;
        CFG_THRESH_MINUS4: thresh_q[1] <= cfg_i.data;
        CFG_THRESH_ZERO:   thresh_q[2] <= cfg_i.data;
        CFG_THRESH_PLUS4:  thresh_q[3] <= cfg_i.data;
        CFG_THRESH_PLUS8:  thresh_q[4] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_go) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      out_acc_q    <= acc;
      out_de_q     <= is_trial ? de : '0;
      out_energy_q <= energy_d;
      out_spin_q   <= is_load_spin ? sv_q : (center ^ acc);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.accepted     = out_acc_q;
  assign result_o.delta_energy = out_de_q;
  assign result_o.energy       = out_energy_q;
  assign result_o.spin_after   = out_spin_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for ising_spin_flip_trial: load and flip-trial words go in, and every result
// word is checked against an in-bench lattice and energy predictor or a directed outcome.
// Depends on isf_pkg, the channel interfaces of isf_if.sv and the top level.
module tb_top;
  import isf_pkg::*;

  localparam int SIDE        = 64;
  localparam int NUM_SITES   = SIDE * SIDE;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_WORDS = 300;
  localparam int ENERGY_TOP    = 16383;
  localparam int ENERGY_BOTTOM = -16384;

  localparam logic [ACTION_W-1:0] ACT_UNUSED      = 2'd3;
  localparam logic [THRESH_W-1:0] ONE_FRACTION    = 33'h1_0000_0000;
  localparam logic [THRESH_W-1:0] THRESH_ALL_ONES = 33'h1_FFFF_FFFF;
  localparam logic [THRESH_W-1:0] PLUS4_AT_RESET  = 33'd78665071;
  localparam logic [THRESH_W-1:0] PLUS8_AT_RESET  = 33'd1440799;
  localparam logic [DRAW_W-1:0]   DRAW_MAX        = 32'hFFFF_FFFF;

  typedef struct {
    logic [ACTION_W-1:0]        action;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic                       spin;
    logic signed [ENERGY_W-1:0] energy;
    logic [DRAW_W-1:0]          draw;
  } trial_word_t;

  typedef struct {
    logic                       accepted;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [ENERGY_W-1:0] energy;
    logic                       spin_after;
  } spin_result_t;

  typedef struct {
    trial_word_t  word;
    bit           typed;
    spin_result_t outcome;
  } directed_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  isf_trial_if  trial_ch ();
  isf_cfg_if    cfg_ch ();
  isf_result_if result_ch ();

  ising_spin_flip_trial #(.SIDE(SIDE)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .trial_i  (trial_ch),
    .cfg_i    (cfg_ch),
    .result_o (result_ch)
  );

  // Predictor state: lattice, running energy and the threshold registers.
  bit                         spin_q [NUM_SITES];
  logic signed [ENERGY_W-1:0] energy_q;
  logic [THRESH_W-1:0]        thresh_q [NUM_THRESH];

  // Sites that have been loaded; only these may ever be read by the block.
  bit site_loaded [NUM_SITES];
  int loaded_sites [$];

  spin_result_t  expected_results [$];
  directed_row_t directed_rows [$];

  logic [COORD_W-1:0] last_row, last_col;
  bit gaps_on;
  int words_sent;
  int error_count;
  int cycle_count;
  int stall_left;

  always #4 clk_i = ~clk_i;

  function automatic int spin_at(int r, int c);
    return spin_q[r * SIDE + c] ? 1 : -1;
  endfunction

  // Energy change of flipping the site, with periodic wrap on both axes.
  function automatic int site_delta(int r, int c);
    int sum;
    sum = spin_at((r + 1) % SIDE, c) + spin_at((r + SIDE - 1) % SIDE, c) +
          spin_at(r, (c + 1) % SIDE) + spin_at(r, (c + SIDE - 1) % SIDE);
    return 2 * spin_at(r, c) * sum;
  endfunction

  // Threshold register that governs a given energy change.
  function automatic int thresh_slot(int de);
    return (de + 8) / 4;
  endfunction

  // Applies one word to the predictor state and returns the result it should give.
  function automatic spin_result_t flip_outcome(trial_word_t w);
    spin_result_t r;
    int site;
    int de;
    int e;
    site = int'(w.row) * SIDE + int'(w.col);
    de = 0;
    r.accepted = 1'b0;
    case (w.action)
      ACT_LOAD_SPIN: spin_q[site] = w.spin;
      ACT_LOAD_ENERGY: energy_q = w.energy;
      ACT_FLIP_TRIAL: begin
        de = site_delta(int'(w.row), int'(w.col));
        if ({1'b0, w.draw} < thresh_q[thresh_slot(de)]) begin
          r.accepted = 1'b1;
          e = int'(energy_q) + de;
          if (e > ENERGY_TOP) e = ENERGY_TOP;
          if (e < ENERGY_BOTTOM) e = ENERGY_BOTTOM;
          energy_q = e[ENERGY_W-1:0];
          spin_q[site] = ~spin_q[site];
        end
      end
      default: ;
    endcase
    r.delta = de[DELTA_W-1:0];
    r.energy = energy_q;
    r.spin_after = spin_q[site];
    return r;
  endfunction

  function automatic trial_word_t random_fields();
    trial_word_t w;
    w.action = ACT_UNUSED;
    w.row    = COORD_W'($urandom_range(0, SIDE - 1));
    w.col    = COORD_W'($urandom_range(0, SIDE - 1));
    w.spin   = 1'($urandom_range(0, 1));
    w.energy = ENERGY_W'($urandom_range(0, 32767));
    w.draw   = $urandom();
    return w;
  endfunction

  function automatic directed_row_t dir_row(logic [ACTION_W-1:0] a, int r, int c, bit s,
                                            int e, logic [DRAW_W-1:0] d, bit typed,
                                            bit acc, int de, int en, bit sa);
    directed_row_t row_item;
    row_item.word = '{a, COORD_W'(r), COORD_W'(c), s, ENERGY_W'(e), d};
    row_item.typed = typed;
    row_item.outcome = '{acc, DELTA_W'(de), ENERGY_W'(en), sa};
    return row_item;
  endfunction

  // Offers one word on the trial channel, possibly after a gap, and records
  // the expected result once the word is taken.
  task automatic send_word(trial_word_t w, bit typed, spin_result_t typed_res);
    spin_result_t predicted;
    int site;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      trial_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    trial_ch.valid        <= 1'b1;
    trial_ch.action       <= w.action;
    trial_ch.row          <= w.row;
    trial_ch.col          <= w.col;
    trial_ch.spin_value   <= w.spin;
    trial_ch.energy_value <= w.energy;
    trial_ch.random_draw  <= w.draw;
    do @(posedge clk_i); while (!trial_ch.ready);
    site = int'(w.row) * SIDE + int'(w.col);
    if (w.action == ACT_LOAD_SPIN && !site_loaded[site]) begin
      site_loaded[site] = 1'b1;
      loaded_sites.insert(loaded_sites.size(), site);
    end
    predicted = flip_outcome(w);
    expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
    words_sent++;
  endtask

  task automatic load_site(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
    trial_word_t w;
    spin_result_t unused;
    w = random_fields();
    w.action = ACT_LOAD_SPIN;
    w.row = r;
    w.col = c;
    send_word(w, 1'b0, unused);
  endtask

  task automatic write_reg(isf_cfg_reg_e idx, logic [THRESH_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    thresh_q[idx] = value;
  endtask

  // Rewrites all five thresholds once the block has drained.
  task automatic set_thresholds(logic [THRESH_W-1:0] m8, logic [THRESH_W-1:0] m4,
                                logic [THRESH_W-1:0] z, logic [THRESH_W-1:0] p4,
                                logic [THRESH_W-1:0] p8);
    trial_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    write_reg(CFG_THRESH_MINUS8, m8);
    write_reg(CFG_THRESH_MINUS4, m4);
    write_reg(CFG_THRESH_ZERO, z);
    write_reg(CFG_THRESH_PLUS4, p4);
    write_reg(CFG_THRESH_PLUS8, p8);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [THRESH_W-1:0] random_thresh();
    return {1'($urandom_range(0, 1)), 32'($urandom())};
  endfunction

  // Random traffic: mostly flip trials whose neighborhood is loaded first,
  // mixed with spin loads, energy loads and unused actions.
  task automatic random_words(int target, bit quiet);
    trial_word_t w;
    spin_result_t unused;
    logic [COORD_W-1:0] r, c;
    logic [COORD_W-1:0] nr [5];
    logic [COORD_W-1:0] nc [5];
    logic [THRESH_W-1:0] thr;
    int pick;
    int site;
    int e;
    int loops;
    loops = 0;
    while (words_sent < target) begin
      if (quiet) gaps_on = 1'b0;
      else if (loops % 40 == 0) gaps_on = ($urandom_range(0, 9) < 7);
      loops++;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        load_site(COORD_W'($urandom_range(0, SIDE - 1)), COORD_W'($urandom_range(0, SIDE - 1)));
      end else if (pick < 20) begin
        w = random_fields();
        w.action = (pick < 16) ? ACT_LOAD_ENERGY : ACT_UNUSED;
        site = loaded_sites[$urandom_range(0, loaded_sites.size() - 1)];
        w.row = COORD_W'(site / SIDE);
        w.col = COORD_W'(site % SIDE);
        if ($urandom_range(0, 3) == 0) begin
          e = $urandom_range(0, 1) ? ENERGY_TOP - int'($urandom_range(0, 12))
                                   : ENERGY_BOTTOM + int'($urandom_range(0, 12));
          w.energy = e[ENERGY_W-1:0];
        end
        send_word(w, 1'b0, unused);
      end else begin
        // Sites near the last one keep back-to-back trials on shared neighbors.
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          r = COORD_W'(last_row + $urandom_range(0, 2) - 1);
          c = COORD_W'(last_col + $urandom_range(0, 2) - 1);
        end else if (pick < 6) begin
          r = $urandom_range(0, 1) ? COORD_W'(SIDE - 1) : '0;
          c = COORD_W'($urandom_range(0, SIDE - 1));
          if ($urandom_range(0, 1)) {r, c} = {c, r};
        end else begin
          r = COORD_W'($urandom_range(0, SIDE - 1));
          c = COORD_W'($urandom_range(0, SIDE - 1));
        end
        last_row = r;
        last_col = c;
        nr = '{r, r + 1'b1, r - 1'b1, r, r};
        nc = '{c, c, c, c + 1'b1, c - 1'b1};
        for (int k = 0; k < 5; k++) begin
          if (!site_loaded[int'(nr[k]) * SIDE + int'(nc[k])]) load_site(nr[k], nc[k]);
        end
        w = random_fields();
        w.action = ACT_FLIP_TRIAL;
        w.row = r;
        w.col = c;
        thr = thresh_q[thresh_slot(site_delta(int'(r), int'(c)))];
        case ($urandom_range(0, 5))
          0: w.draw = '0;
          1: w.draw = DRAW_MAX;
          2: if (thr != '0) w.draw = DRAW_W'(thr - 1'b1);
          3: if (thr <= {1'b0, DRAW_MAX}) w.draw = thr[DRAW_W-1:0];
          default: ;
        endcase
        send_word(w, 1'b0, unused);
      end
    end
  endtask

  // Result side: ready drops in random bursts while gaps are enabled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk_i) begin : check_result
    spin_result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation pending");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, result_ch.accepted);
          error_count++;
        end
        if (result_ch.delta_energy !== want.delta) begin
          $error("delta_energy: expected %0d, got %0d", want.delta, result_ch.delta_energy);
          error_count++;
        end
        if (result_ch.energy !== want.energy) begin
          $error("energy: expected %0d, got %0d", want.energy, result_ch.energy);
          error_count++;
        end
        if (result_ch.spin_after !== want.spin_after) begin
          $error("spin_after: expected %0d, got %0d", want.spin_after, result_ch.spin_after);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    trial_ch.valid        <= 1'b0;
    trial_ch.action       <= ACT_LOAD_SPIN;
    trial_ch.row          <= '0;
    trial_ch.col          <= '0;
    trial_ch.spin_value   <= 1'b0;
    trial_ch.energy_value <= '0;
    trial_ch.random_draw  <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_THRESH_MINUS8;
    cfg_ch.data           <= '0;
    thresh_q = '{ONE_FRACTION, ONE_FRACTION, ONE_FRACTION, PLUS4_AT_RESET, PLUS8_AT_RESET};
    energy_q = '0;
    last_row = '0;
    last_col = '0;
    gaps_on = 1'b1;

    // Directed words around the wrapping corners, with the reset thresholds.
    directed_rows = '{
      dir_row(ACT_LOAD_SPIN,    0,  0, 1, 0, '0, 1, 0, 0, 0, 1),
      dir_row(ACT_LOAD_SPIN,    1,  0, 1, 0, '0, 1, 0, 0, 0, 1),
      dir_row(ACT_LOAD_SPIN,   63,  0, 1, 0, '0, 1, 0, 0, 0, 1),
      dir_row(ACT_LOAD_SPIN,    0,  1, 1, 0, '0, 1, 0, 0, 0, 1),
      dir_row(ACT_LOAD_SPIN,    0, 63, 1, 0, '0, 1, 0, 0, 0, 1),
      // Energy at the top, then an uphill flip that must saturate.
      dir_row(ACT_LOAD_ENERGY,  0,  0, 0, ENERGY_TOP, '0, 1, 0, 0, ENERGY_TOP, 1),
      dir_row(ACT_FLIP_TRIAL,   0,  0, 0, 0, '0, 1, 1, 8, ENERGY_TOP, 0),
      // Full-scale threshold accepts even the largest draw.
      dir_row(ACT_FLIP_TRIAL,   0,  0, 0, 0, DRAW_MAX, 1, 1, -8, ENERGY_TOP - 8, 1),
      dir_row(ACT_LOAD_ENERGY,  0,  0, 0, ENERGY_BOTTOM, '0, 1, 0, 0, ENERGY_BOTTOM, 1),
      dir_row(ACT_FLIP_TRIAL,   0,  0, 0, 0, DRAW_MAX, 1, 0, 8, ENERGY_BOTTOM, 1),
      dir_row(ACT_LOAD_SPIN,    0,  0, 0, 0, '0, 1, 0, 0, ENERGY_BOTTOM, 0),
      // Downhill flip at the bottom must saturate.
      dir_row(ACT_FLIP_TRIAL,   0,  0, 0, 0, '0, 1, 1, -8, ENERGY_BOTTOM, 1),
      // Unused action changes nothing.
      dir_row(ACT_UNUSED,      63,  0, 1, ENERGY_TOP, DRAW_MAX, 1, 0, 0, ENERGY_BOTTOM, 1),
      dir_row(ACT_LOAD_SPIN,   63, 63, 0, -1, DRAW_MAX, 1, 0, 0, ENERGY_BOTTOM, 0),
      dir_row(ACT_LOAD_ENERGY, 63, 63, 0, 0, '0, 1, 0, 0, 0, 0),
      dir_row(ACT_LOAD_SPIN,   62, 63, 0, 0, '0, 0, 0, 0, 0, 0),
      dir_row(ACT_LOAD_SPIN,   63, 62, 1, 0, '0, 0, 0, 0, 0, 0),
      dir_row(ACT_FLIP_TRIAL,  63, 63, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0),
      // Draws one below and at the plus-four threshold.
      dir_row(ACT_FLIP_TRIAL,  63, 63, 0, 0, 32'd78665070, 0, 0, 0, 0, 0),
      dir_row(ACT_FLIP_TRIAL,  63, 63, 0, 0, 32'h1234_5678, 0, 0, 0, 0, 0),
      dir_row(ACT_FLIP_TRIAL,  63, 63, 0, 0, 32'd78665071, 0, 0, 0, 0, 0),
      dir_row(ACT_LOAD_SPIN,   63, 62, 0, 0, '0, 0, 0, 0, 0, 0),
      dir_row(ACT_FLIP_TRIAL,  63, 63, 1, 0, DRAW_MAX, 0, 0, 0, 0, 0)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].outcome);
    end

    // Random phases, each under a different threshold setting.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: set_thresholds(ONE_FRACTION, ONE_FRACTION, ONE_FRACTION, ONE_FRACTION, ONE_FRACTION);
        2: set_thresholds('0, '0, '0, '0, '0);
        3: set_thresholds(THRESH_ALL_ONES, THRESH_ALL_ONES, THRESH_ALL_ONES,
                          THRESH_ALL_ONES, THRESH_ALL_ONES);
        4: set_thresholds(random_thresh(), random_thresh(), random_thresh(),
                          random_thresh(), random_thresh());
        5: set_thresholds(ONE_FRACTION, ONE_FRACTION, ONE_FRACTION,
                          {1'b0, 32'($urandom())}, {1'b0, 32'($urandom_range(0, 1 << 24))});
        default: ;
      endcase
      random_words(words_sent + PHASE_WORDS, phase == 5);
    end

    // Drain and let the block settle before the verdict.
    trial_ch.valid <= 1'b0;
    gaps_on = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
